FILE: design/vms_pkg.sv
// Shared types, codes and constants for the vessel mission sequencer.
`default_nettype none

package vms_pkg;

    // Route length limit and field widths.
    localparam int unsigned MAX_ROUTE = 255;
    localparam int unsigned WP_W      = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned IN_DATA_W = 40;
    localparam int unsigned OUT_DATA_W = 24;

    // System modes.
    localparam logic [3:0] M_BOOT     = 4'd0;
    localparam logic [3:0] M_IDLE     = 4'd1;
    localparam logic [3:0] M_MANUAL   = 4'd2;
    localparam logic [3:0] M_AUTO     = 4'd3;
    localparam logic [3:0] M_MISSION  = 4'd4;
    localparam logic [3:0] M_PAUSED   = 4'd5;
    localparam logic [3:0] M_HOME     = 4'd6;
    localparam logic [3:0] M_SHUTDOWN = 4'd7;
    localparam logic [3:0] M_FAULT    = 4'd8;

    // Mission stages.
    localparam logic [3:0] S_NONE    = 4'd0;
    localparam logic [3:0] S_GOTO    = 4'd1;
    localparam logic [3:0] S_PREP    = 4'd2;
    localparam logic [3:0] S_RINSE   = 4'd3;
    localparam logic [3:0] S_SAMPLE  = 4'd4;
    localparam logic [3:0] S_POST    = 4'd5;
    localparam logic [3:0] S_DONE    = 4'd6;
    localparam logic [3:0] S_ABORTED = 4'd7;
    localparam logic [3:0] S_FAILED  = 4'd8;

    // Action codes.
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_ROUTE  = 2'd1;
    localparam logic [1:0] ACT_REPORT = 2'd2;

    // Request kinds on the input side.
    localparam logic REQ_COMMAND = 1'b0;
    localparam logic REQ_TIMER   = 1'b1;

    // Timer codes.
    localparam logic [2:0] TMR_TICK           = 3'd0;
    localparam logic [2:0] TMR_SAMPLE_TIMEOUT = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_ROUTE_LENGTH   = 1'b0;
    localparam logic CFG_RETURN_HOME_MS = 1'b1;

    // Operations handed from the front end to the back end. Command codes
    // map one to one onto the first sixteen operations.
    localparam logic [4:0] OP_START      = 5'd0;
    localparam logic [4:0] OP_MANUAL     = 5'd1;
    localparam logic [4:0] OP_AUTO       = 5'd2;
    localparam logic [4:0] OP_UPLOAD     = 5'd3;
    localparam logic [4:0] OP_MISSION    = 5'd4;
    localparam logic [4:0] OP_PAUSE      = 5'd5;
    localparam logic [4:0] OP_RESUME     = 5'd6;
    localparam logic [4:0] OP_ABORT      = 5'd7;
    localparam logic [4:0] OP_HOME       = 5'd8;
    localparam logic [4:0] OP_STOP       = 5'd9;
    localparam logic [4:0] OP_REACHED    = 5'd10;
    localparam logic [4:0] OP_PREP_DONE  = 5'd11;
    localparam logic [4:0] OP_RINSE_DONE = 5'd12;
    localparam logic [4:0] OP_SAMPLE_DONE = 5'd13;
    localparam logic [4:0] OP_POST_DONE  = 5'd14;
    localparam logic [4:0] OP_HOME_DONE  = 5'd15;
    localparam logic [4:0] OP_TICK       = 5'd16;
    localparam logic [4:0] OP_TIMEOUT    = 5'd17;
    localparam logic [4:0] OP_NOP        = 5'd18;

    // One classified item waiting for the back end.
    typedef struct packed {
        logic [4:0]        opcode;
        logic [2:0]        err;
        logic [TIME_W-1:0] time_ms;
    } op_t;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [WP_W-1:0]   route_length;
        logic [TIME_W-1:0] return_home_ms;
    } cfg_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic valid;
        op_t  op;
    } queue_head_t;

endpackage

`default_nettype wire

FILE: design/vms_front.sv
// Front end: accepts input items and classifies them into operations.
`default_nettype none

module vms_front
    import vms_pkg::*;
(
    input  wire logic                  req_type,
    input  wire logic [3:0]            command_code,
    input  wire logic [2:0]            timer_code,
    input  wire logic [TIME_W-1:0]     time_ms,
    output op_t                        op
);

    // Commands pass their code through; timer events split into tick,
    // timeout and ignored codes.
    always_comb
    begin
        op.time_ms = time_ms;
        op.err     = 3'd0;
        if (req_type == REQ_COMMAND)
        begin
            op.opcode = {1'b0, command_code};
        end
        else if (timer_code == TMR_TICK)
        begin
            op.opcode = OP_TICK;
        end
        else if (timer_code <= TMR_SAMPLE_TIMEOUT)
        begin
            op.opcode = OP_TIMEOUT;
            op.err    = timer_code;
        end
        else
        begin
            op.opcode = OP_NOP;
        end
    end

endmodule

`default_nettype wire

FILE: design/vms_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none

module vms_queue
    import vms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire op_t   push_op,
    output logic       full,
    input  wire logic  pop,
    output queue_head_t head
);

    op_t        mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.op    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

FILE: design/vms_back.sv
// Back end: carries out operations on the mission state and registers results.
`default_nettype none

module vms_back
    import vms_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cfg_t           cfg,
    input  wire queue_head_t    head,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic [3:0]        mode_reg,  mode_next;
    logic [3:0]        stage_reg, stage_next;
    logic [WP_W-1:0]   wp_reg,    wp_next;
    logic [2:0]        err_reg,   err_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [1:0]        action;
    logic              changed;
    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [WP_W:0]     wp_inc;
    logic [TIME_W-1:0] elapsed;
    logic              in_mission;

    assign pop       = head.valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign wp_inc     = {1'b0, wp_reg} + {{WP_W{1'b0}}, 1'b1};
    assign elapsed    = head.op.time_ms - start_reg;
    assign in_mission = (mode_reg == M_MISSION);

    // Next mission state for the operation at the head of the queue.
    always_comb
    begin
        mode_next  = mode_reg;
        stage_next = stage_reg;
        wp_next    = wp_reg;
        err_next   = err_reg;
        start_next = start_reg;
        action     = ACT_NONE;
        case (head.op.opcode)
            OP_START:
                if (mode_reg == M_BOOT) mode_next = M_IDLE;
            OP_MANUAL:
                if (mode_reg == M_IDLE) mode_next = M_MANUAL;
            OP_AUTO:
                if (mode_reg == M_IDLE || mode_reg == M_MANUAL) mode_next = M_AUTO;
            OP_UPLOAD:
                action = ACT_ROUTE;
            OP_MISSION:
                if (mode_reg == M_AUTO)
                begin
                    mode_next  = M_MISSION;
                    wp_next    = '0;
                    err_next   = 3'd0;
                    stage_next = S_GOTO;
                    start_next = head.op.time_ms;
                end
            OP_PAUSE:
                if (mode_reg == M_MISSION || mode_reg == M_AUTO) mode_next = M_PAUSED;
            OP_RESUME:
                if (mode_reg == M_PAUSED) mode_next = M_AUTO;
            OP_ABORT:
            begin
                mode_next  = M_HOME;
                stage_next = S_ABORTED;
                start_next = head.op.time_ms;
            end
            OP_HOME:
            begin
                mode_next  = M_HOME;
                start_next = head.op.time_ms;
            end
            OP_STOP:
                mode_next = M_SHUTDOWN;
            OP_REACHED:
                if (in_mission && stage_reg == S_GOTO)
                begin
                    stage_next = S_PREP;
                    start_next = head.op.time_ms;
                end
            OP_PREP_DONE:
                if (in_mission && stage_reg == S_PREP)
                begin
                    stage_next = S_RINSE;
                    start_next = head.op.time_ms;
                end
            OP_RINSE_DONE:
                if (in_mission && stage_reg == S_RINSE)
                begin
                    stage_next = S_SAMPLE;
                    start_next = head.op.time_ms;
                end
            OP_SAMPLE_DONE:
                if (in_mission && stage_reg == S_SAMPLE)
                begin
                    stage_next = S_POST;
                    start_next = head.op.time_ms;
                end
            OP_POST_DONE:
                if (in_mission && stage_reg == S_POST)
                begin
                    // The waypoint saturates, the route check uses the full count.
                    wp_next    = wp_inc[WP_W] ? {WP_W{1'b1}} : wp_inc[WP_W-1:0];
                    start_next = head.op.time_ms;
                    if (wp_inc >= {1'b0, cfg.route_length})
                    begin
                        mode_next  = M_HOME;
                        stage_next = S_DONE;
                    end
                    else
                    begin
                        stage_next = S_GOTO;
                    end
                end
            OP_HOME_DONE:
                if (mode_reg == M_HOME)
                begin
                    mode_next  = M_IDLE;
                    stage_next = S_NONE;
                    err_next   = 3'd0;
                end
            OP_TICK:
                if (mode_reg == M_HOME && elapsed >= cfg.return_home_ms
                    && stage_reg != S_DONE && stage_reg != S_ABORTED)
                begin
                    mode_next  = M_IDLE;
                    stage_next = S_NONE;
                    err_next   = 3'd0;
                end
            OP_TIMEOUT:
            begin
                mode_next  = M_FAULT;
                stage_next = S_FAILED;
                err_next   = head.op.err;
                action     = ACT_REPORT;
            end
            default:
            begin
                action = ACT_NONE;
            end
        endcase
        changed = (mode_next != mode_reg) || (stage_next != stage_reg)
                  || (wp_next != wp_reg) || (err_next != err_reg);
    end

    // Mission state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_BOOT;
            stage_reg     <= S_NONE;
            wp_reg        <= '0;
            err_reg       <= 3'd0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg  <= mode_next;
                stage_reg <= stage_next;
                wp_reg    <= wp_next;
                err_reg   <= err_next;
                start_reg <= start_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= {2'b00, changed, action, err_next, wp_next,
                             stage_next, mode_next};
        end
    end

endmodule

`default_nettype wire

FILE: design/vessel_mission_sequencer.sv
// Top level of the vessel mission sequencer.
// With an empty queue an accepted item is stored in the queue, then popped by the back end, which registers its result.
// Throughput: one item per cycle while the result output is not stalled, set by the state update in the back end.
// While a result is stalled the two-entry queue takes up to two more items, then stalls.
// Reset (rst_n low, asynchronous): mode boot, stage none, waypoint and error zero,
// queue and output empty, route_length 3 and return_home_ms 30000.
`default_nettype none

module vessel_mission_sequencer
    import vms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // command_code [3:0], timer_code [6:4], time_ms [38:7], zero [39]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [0]
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // system_mode [3:0], mission_stage [7:4], waypoint_index [15:8],
    // error_code [18:16], action_code [20:19], snapshot_changed [21], zero [23:22]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [TIME_W-1:0]     cfg_wdata
);

    cfg_t        cfg_reg;
    logic [WP_W-1:0] route_wr;
    op_t         front_op;
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    queue_head_t q_head;

    // Route length writes are clamped to one through the maximum.
    always_comb
    begin
        route_wr = cfg_wdata[WP_W-1:0];
        if (route_wr == '0)
        begin
            route_wr = {{(WP_W-1){1'b0}}, 1'b1};
        end
        else if (route_wr > WP_W'(MAX_ROUTE))
        begin
            route_wr = WP_W'(MAX_ROUTE);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.route_length   <= WP_W'(3);
            cfg_reg.return_home_ms <= TIME_W'(30000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROUTE_LENGTH:   cfg_reg.route_length   <= route_wr;
                CFG_RETURN_HOME_MS: cfg_reg.return_home_ms <= cfg_wdata;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    vms_front u_front (
        .req_type     (s_axis_tuser),
        .command_code (s_axis_tdata[3:0]),
        .timer_code   (s_axis_tdata[6:4]),
        .time_ms      (s_axis_tdata[38:7]),
        .op           (front_op)
    );

    vms_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (front_op),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head)
    );

    vms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: design/vms_checker.sv
// Port-level checks for the vessel mission sequencer, bound to the top level.
`default_nettype none

module vms_checker
    import vms_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // No result is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result offered during reset");

    // A stalled result stays offered and unchanged.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A failure report always shows the fault snapshot with a nonzero error.
    a_report_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[20:19] == ACT_REPORT |->
        m_axis_tdata[3:0] == M_FAULT && m_axis_tdata[7:4] == S_FAILED
        && m_axis_tdata[18:16] != 3'd0)
        else $error("failure report without fault snapshot");

    // A route upload notice never comes with a state change.
    a_upload_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[20:19] == ACT_ROUTE |-> !m_axis_tdata[21])
        else $error("route upload changed the snapshot");

    // The padding bits are zero and the mode and stage codes stay in range.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00
        && m_axis_tdata[3:0] <= M_FAULT && m_axis_tdata[7:4] <= S_FAILED)
        else $error("result codes out of range");

endmodule

bind vessel_mission_sequencer vms_checker u_vms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/vms_snapshot_checker.sv
// Checker for the vessel mission sequencer: predicts each snapshot and compares it.
module vms_snapshot_checker
    import vms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    // command_code [3:0], timer_code [6:4], time_ms [38:7], zero [39]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [0]
    input  wire logic                  s_axis_tuser,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // system_mode [3:0], mission_stage [7:4], waypoint_index [15:8],
    // error_code [18:16], action_code [20:19], snapshot_changed [21], zero [23:22]
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [TIME_W-1:0]     cfg_wdata,
    output int                         fail_count,
    output int                         outstanding,
    output int                         items_taken,
    output int                         results_checked
);

    // Fields are listed from the top bit down so that the struct overlays
    // m_axis_tdata[21:0] directly.
    typedef struct packed {
        logic            changed;
        logic [1:0]      action;
        logic [2:0]      err;
        logic [WP_W-1:0] waypoint;
        logic [3:0]      stage;
        logic [3:0]      mode;
    } sequencer_snapshot_t;

    localparam int MAX_PRINTED = 100;

    // Predicted sequencer state and configuration.
    logic [3:0]        mode_q;
    logic [3:0]        stage_q;
    logic [WP_W-1:0]   wp_q;
    logic [2:0]        err_q;
    logic [TIME_W-1:0] stage_t0;
    logic [WP_W-1:0]   route_len;
    logic [TIME_W-1:0] home_ms;

    sequencer_snapshot_t expected_snapshots[$];

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("%0t: result %0d: %s", $time, results_checked, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    function automatic logic in_mission_stage(input logic [3:0] stage);
        return mode_q == M_MISSION && stage_q == stage;
    endfunction

    // A route length of zero is kept as one; eight bits never exceed MAX_ROUTE.
    function automatic void apply_register(input logic idx, input logic [TIME_W-1:0] value);
        if (idx == CFG_ROUTE_LENGTH)
            route_len = (value[WP_W-1:0] == '0) ? 8'd1 : value[WP_W-1:0];
        else
            home_ms = value;
    endfunction

    // Apply one event to the predicted state and return the snapshot it gives.
    function automatic sequencer_snapshot_t advance_sequencer(input logic kind,
        input logic [3:0] cmd, input logic [2:0] tmr, input logic [TIME_W-1:0] now);
        sequencer_snapshot_t res;
        logic [3:0]        m0;
        logic [3:0]        s0;
        logic [WP_W-1:0]   w0;
        logic [2:0]        e0;
        logic [1:0]        act;
        logic [WP_W:0]     next_wp;
        logic [TIME_W-1:0] elapsed;
        m0 = mode_q;
        s0 = stage_q;
        w0 = wp_q;
        e0 = err_q;
        act = ACT_NONE;
        if (kind == REQ_COMMAND)
        begin
            case ({1'b0, cmd})
                OP_START:
                    if (mode_q == M_BOOT)
                        mode_q = M_IDLE;
                OP_MANUAL:
                    if (mode_q == M_IDLE)
                        mode_q = M_MANUAL;
                OP_AUTO:
                    if (mode_q == M_IDLE || mode_q == M_MANUAL)
                        mode_q = M_AUTO;
                OP_UPLOAD:
                    act = ACT_ROUTE;
                OP_MISSION:
                    if (mode_q == M_AUTO)
                    begin
                        mode_q = M_MISSION;
                        wp_q = '0;
                        err_q = '0;
                        stage_q = S_GOTO;
                        stage_t0 = now;
                    end
                OP_PAUSE:
                    if (mode_q == M_MISSION || mode_q == M_AUTO)
                        mode_q = M_PAUSED;
                OP_RESUME:
                    if (mode_q == M_PAUSED)
                        mode_q = M_AUTO;
                OP_ABORT:
                begin
                    mode_q = M_HOME;
                    stage_q = S_ABORTED;
                    stage_t0 = now;
                end
                OP_HOME:
                begin
                    mode_q = M_HOME;
                    stage_t0 = now;
                end
                OP_STOP:
                    mode_q = M_SHUTDOWN;
                OP_REACHED:
                    if (in_mission_stage(S_GOTO))
                    begin
                        stage_q = S_PREP;
                        stage_t0 = now;
                    end
                OP_PREP_DONE:
                    if (in_mission_stage(S_PREP))
                    begin
                        stage_q = S_RINSE;
                        stage_t0 = now;
                    end
                OP_RINSE_DONE:
                    if (in_mission_stage(S_RINSE))
                    begin
                        stage_q = S_SAMPLE;
                        stage_t0 = now;
                    end
                OP_SAMPLE_DONE:
                    if (in_mission_stage(S_SAMPLE))
                    begin
                        stage_q = S_POST;
                        stage_t0 = now;
                    end
                OP_POST_DONE:
                    if (in_mission_stage(S_POST))
                    begin
                        // The index saturates, but the route test uses the full count.
                        next_wp = {1'b0, wp_q} + 9'd1;
                        wp_q = (next_wp > 9'd255) ? 8'hFF : next_wp[WP_W-1:0];
                        if (next_wp >= {1'b0, route_len})
                        begin
                            mode_q = M_HOME;
                            stage_q = S_DONE;
                        end
                        else
                            stage_q = S_GOTO;
                        stage_t0 = now;
                    end
                OP_HOME_DONE:
                    if (mode_q == M_HOME)
                    begin
                        mode_q = M_IDLE;
                        stage_q = S_NONE;
                        err_q = '0;
                    end
                default:
                    act = ACT_NONE;
            endcase
        end
        else if (tmr == TMR_TICK)
        begin
            // Return-home ends on time only while the mission is unfinished.
            elapsed = now - stage_t0;
            if (mode_q == M_HOME && elapsed >= home_ms && stage_q != S_DONE
                && stage_q != S_ABORTED)
            begin
                mode_q = M_IDLE;
                stage_q = S_NONE;
                err_q = '0;
            end
        end
        else if (tmr <= TMR_SAMPLE_TIMEOUT)
        begin
            // Any timeout forces the fault mode, whatever the current mode.
            stage_q = S_FAILED;
            mode_q = M_FAULT;
            err_q = tmr;
            act = ACT_REPORT;
        end
        res.mode = mode_q;
        res.stage = stage_q;
        res.waypoint = wp_q;
        res.err = err_q;
        res.action = act;
        res.changed = (m0 != mode_q) || (s0 != stage_q) || (w0 != wp_q) || (e0 != err_q);
        return res;
    endfunction

    // Track register writes, predict accepted items, compare accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        sequencer_snapshot_t want;
        sequencer_snapshot_t seen;
        if (!rst_n)
        begin
            mode_q = M_BOOT;
            stage_q = S_NONE;
            wp_q = '0;
            err_q = '0;
            stage_t0 = '0;
            route_len = 8'd3;
            home_ms = 32'd30000;
            expected_snapshots.delete();
            fail_count = 0;
            outstanding <= 0;
            items_taken <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (cfg_we)
                apply_register(cfg_index, cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_snapshots.insert(expected_snapshots.size(),
                    advance_sequencer(s_axis_tuser, s_axis_tdata[3:0],
                                      s_axis_tdata[6:4], s_axis_tdata[38:7]));
                items_taken <= items_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = m_axis_tdata[21:0];
                if (expected_snapshots.size() == 0)
                    report_mismatch("result arrived with no item waiting for it");
                else
                begin
                    want = expected_snapshots.pop_front();
                    check_field("system_mode", 32'(seen.mode), 32'(want.mode));
                    check_field("mission_stage", 32'(seen.stage), 32'(want.stage));
                    check_field("waypoint_index", 32'(seen.waypoint), 32'(want.waypoint));
                    check_field("error_code", 32'(seen.err), 32'(want.err));
                    check_field("action_code", 32'(seen.action), 32'(want.action));
                    check_field("snapshot_changed", 32'(seen.changed), 32'(want.changed));
                end
                results_checked <= results_checked + 1;
            end
            outstanding <= expected_snapshots.size();
        end
    end

endmodule

FILE: tb/tb_vessel_mission_sequencer.sv
// Testbench top for the vessel mission sequencer: stimulus, output stalls and verdict.
module tb_vessel_mission_sequencer;
    import vms_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 240;
    localparam int PHASE_ITEMS  = 175;
    localparam int PHASES       = 6;

    // Timer codes not named in the package.
    localparam logic [2:0] TMR_GOTO_TIMEOUT  = 3'd1;
    localparam logic [2:0] TMR_UNUSED_LO     = 3'd5;
    localparam logic [2:0] TMR_UNUSED_HI     = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // command_code [3:0], timer_code [6:4], time_ms [38:7], zero [39]
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // req_type [0]
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // system_mode [3:0], mission_stage [7:4], waypoint_index [15:8],
    // error_code [18:16], action_code [20:19], snapshot_changed [21], zero [23:22]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [TIME_W-1:0]     cfg_wdata;

    int fail_count;
    int outstanding;
    int items_taken;
    int results_checked;

    logic [TIME_W-1:0] now_ms;
    int                hold_asks = 0;
    int                noise_pct;
    int                settings_done;
    bit                steady_sender;

    vessel_mission_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    vms_snapshot_checker snap_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .items_taken     (items_taken),
        .results_checked (results_checked)
    );

    // Clock with a period of four time units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle gap before the next item: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_sender || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_event(input logic kind, input logic [3:0] cmd, input logic [2:0] tmr,
                              input logic [TIME_W-1:0] stamp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, stamp, tmr, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // The field that the event kind does not use carries random bits.
    task automatic cmd_at(input logic [4:0] op, input logic [TIME_W-1:0] stamp);
        send_event(REQ_COMMAND, op[3:0], 3'($urandom), stamp);
    endtask

    task automatic timer_at(input logic [2:0] code, input logic [TIME_W-1:0] stamp);
        send_event(REQ_TIMER, 4'($urandom), code, stamp);
    endtask

    // Next command of a sequence, sometimes preceded by a random event.
    task automatic send_cmd(input logic [4:0] op);
        if ($urandom_range(0, 49) == 0)
            now_ms = $urandom();
        else
            now_ms = now_ms + $urandom_range(0, 40);
        if ($urandom_range(0, 99) < noise_pct)
        begin
            if ($urandom_range(0, 1) == 0)
                send_event(1'($urandom), 4'($urandom), 3'($urandom), now_ms);
            else
                send_event(1'($urandom), 4'($urandom), 3'($urandom), $urandom());
        end
        cmd_at(op, now_ms);
    endtask

    // Stop offering items and wait until every result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [TIME_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Short fixed sequence: guards in boot, mode steps, one leg, wrap of time.
    task automatic run_directed();
        timer_at(TMR_TICK, 32'h0000_0000);
        send_event(REQ_COMMAND, OP_MANUAL[3:0], 3'h7, 32'hFFFF_FFFF);
        send_event(REQ_TIMER, 4'h0, TMR_UNUSED_LO, 32'hFFFF_FFFF);
        send_event(REQ_TIMER, 4'hF, TMR_UNUSED_HI, 32'h8000_0000);
        cmd_at(OP_START, 32'd1);
        cmd_at(OP_MANUAL, 32'd2);
        cmd_at(OP_AUTO, 32'd3);
        cmd_at(OP_UPLOAD, 32'd4);
        cmd_at(OP_PAUSE, 32'd5);
        cmd_at(OP_RESUME, 32'd6);
        cmd_at(OP_MISSION, 32'd100);
        cmd_at(OP_REACHED, 32'd200);
        cmd_at(OP_PREP_DONE, 32'd300);
        cmd_at(OP_RINSE_DONE, 32'd400);
        cmd_at(OP_SAMPLE_DONE, 32'd500);
        cmd_at(OP_POST_DONE, 32'd600);
        cmd_at(OP_PAUSE, 32'd700);
        cmd_at(OP_STOP, 32'd800);
        // A timeout acts even in shutdown.
        timer_at(TMR_GOTO_TIMEOUT, 32'd900);
        // Return home across the wrap of the millisecond counter.
        cmd_at(OP_HOME, 32'hFFFF_FFF0);
        timer_at(TMR_TICK, 32'd5);
        timer_at(TMR_TICK, 32'd29984);
        // An aborted run waits for the home-done command, not for the tick.
        cmd_at(OP_ABORT, 32'd40000);
        timer_at(TMR_TICK, 32'hF000_0000);
        cmd_at(OP_HOME_DONE, 32'hF000_0001);
    endtask

    // One mission: recover to auto, run some legs, then end in one of several ways.
    task automatic run_mission(input int route, input logic [TIME_W-1:0] home_val);
        int          legs;
        int          ending;
        logic [TIME_W-1:0] home_at;
        cmd_at(OP_HOME, now_ms);
        send_cmd(OP_HOME_DONE);
        send_cmd(OP_START);
        if ($urandom_range(0, 1) == 0)
            send_cmd(OP_MANUAL);
        if ($urandom_range(0, 3) == 0)
            send_cmd(OP_UPLOAD);
        send_cmd(OP_AUTO);
        if ($urandom_range(0, 5) == 0)
        begin
            send_cmd(OP_PAUSE);
            send_cmd(OP_RESUME);
        end
        send_cmd(OP_MISSION);
        if (route > 8)
            legs = $urandom_range(1, 12);
        else if ($urandom_range(0, 2) == 0)
            legs = $urandom_range(1, route);
        else
            legs = route;
        for (int leg = 0; leg < legs; leg++)
        begin
            send_cmd(OP_REACHED);
            send_cmd(OP_PREP_DONE);
            send_cmd(OP_RINSE_DONE);
            send_cmd(OP_SAMPLE_DONE);
            send_cmd(OP_POST_DONE);
            if ($urandom_range(0, 7) == 0)
                timer_at(TMR_TICK, now_ms);
        end
        if (legs >= route)
        begin
            // Finished route: the tick must not leave return-home.
            now_ms = now_ms + home_val;
            timer_at(TMR_TICK, now_ms);
            send_cmd(OP_HOME_DONE);
        end
        else
        begin
            ending = $urandom_range(0, 3);
            if (ending == 0)
            begin
                // Ticks just before and exactly at the return-home time.
                send_cmd(OP_HOME);
                home_at = now_ms;
                if (home_val != '0)
                    timer_at(TMR_TICK, home_at + home_val - 32'd1);
                timer_at(TMR_TICK, home_at + home_val);
                now_ms = home_at + home_val;
            end
            else if (ending == 1)
                send_cmd(OP_ABORT);
            else if (ending == 2)
                timer_at(3'($urandom_range(1, 4)), now_ms);
            else
                send_cmd(OP_STOP);
        end
    endtask

    // Output side: random stalls, stall-free stretches and the long hold-off.
    initial
    begin
        int stretch;
        int r;
        int hold_served;
        hold_served = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_served)
            begin
                hold_served = hold_asks;
                m_axis_tready <= 1'b0;
                stretch = LONG_HOLD;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    m_axis_tready <= 1'b1;
                    stretch = $urandom_range(40, 80);
                end
                else if (r < 65)
                begin
                    m_axis_tready <= 1'b1;
                    stretch = $urandom_range(1, 6);
                end
                else if (r < 93)
                begin
                    m_axis_tready <= 1'b0;
                    stretch = $urandom_range(1, 3);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    stretch = $urandom_range(8, 30);
                end
            end
            repeat (stretch - 1) @(posedge clk);
        end
    end

    // Cycle limit on the whole run.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("vessel_mission_sequencer: mismatch");
        $finish;
    end

    // Reset, directed items, then random phases under several register settings.
    initial
    begin
        logic [TIME_W-1:0] route_raw;
        logic [TIME_W-1:0] home_val;
        int                route_eff;
        int                goal;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= 1'b0;
        cfg_wdata     <= '0;
        rst_n         <= 1'b0;
        now_ms = '0;
        noise_pct = 0;
        settings_done = 1;
        steady_sender = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part runs with the reset values of the registers.
        run_directed();

        for (int p = 0; p < PHASES; p++)
        begin
            noise_pct = 8;
            steady_sender = 1'b0;
            case (p)
                0:
                begin
                    route_raw = 32'h0000_0001;
                    home_val = 32'h0000_0000;
                end
                1:
                begin
                    route_raw = 32'hA5A5_A5FF;
                    home_val = 32'hFFFF_FFFF;
                    steady_sender = 1'b1;
                end
                2:
                begin
                    route_raw = 32'h0000_0000;
                    home_val = $urandom_range(1, 500);
                end
                3:
                begin
                    route_raw = {24'($urandom), 8'($urandom_range(2, 6))};
                    home_val = $urandom_range(0, 3000);
                end
                4:
                begin
                    route_raw = 32'd3;
                    home_val = 32'd30000;
                    noise_pct = 25;
                end
                default:
                begin
                    route_raw = $urandom();
                    home_val = $urandom();
                end
            endcase
            drain_results();
            write_register(CFG_ROUTE_LENGTH, route_raw);
            write_register(CFG_RETURN_HOME_MS, home_val);
            settings_done++;
            route_eff = (route_raw[7:0] == 8'd0) ? 1 : int'(route_raw[7:0]);
            // Hold the output off while the sender keeps offering items.
            if (p == 1 || p == 4)
                hold_asks <= hold_asks + 1;
            goal = items_taken + PHASE_ITEMS;
            while (items_taken < goal)
                run_mission(route_eff, home_val);
        end

        drain_results();
        $display("Run covered %0d items and %0d results under %0d register settings,",
                 items_taken, results_checked, settings_done);
        $display("including full routes, refused commands, timeouts and long output stalls.");
        if (fail_count == 0)
            $display("vessel_mission_sequencer: match");
        else
            $display("vessel_mission_sequencer: mismatch");
        $finish;
    end

endmodule
